### rtl/mrf_pkg.sv
package mrf_pkg;

   // frame layout, in transmission order
   localparam int IDX_W = 4;

   localparam logic [IDX_W-1:0] IDX_SLAVE    = 4'd0;
   localparam logic [IDX_W-1:0] IDX_FUNC     = 4'd1;
   localparam logic [IDX_W-1:0] IDX_REG_HI   = 4'd2;
   localparam logic [IDX_W-1:0] IDX_REG_LO   = 4'd3;
   localparam logic [IDX_W-1:0] IDX_QTY_HI   = 4'd4;
   localparam logic [IDX_W-1:0] IDX_QTY_LO   = 4'd5;
   localparam logic [IDX_W-1:0] IDX_BCOUNT   = 4'd6;
   localparam logic [IDX_W-1:0] IDX_VAL_HI   = 4'd7;
   localparam logic [IDX_W-1:0] IDX_VAL_LO   = 4'd8;
   localparam logic [IDX_W-1:0] IDX_CRC_RD   = 4'd6;
   localparam logic [IDX_W-1:0] IDX_CRC_WR   = 4'd9;
   localparam logic [IDX_W-1:0] IDX_LAST_RD  = 4'd7;
   localparam logic [IDX_W-1:0] IDX_LAST_WR  = 4'd10;

   localparam logic        OP_READ  = 1'b0;
   localparam logic        OP_WRITE = 1'b1;

   localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
   localparam logic [7:0]  FN_WRITE_MULTI  = 8'h10;
   localparam logic [7:0]  QUANTITY_HI     = 8'h00;
   localparam logic [7:0]  QUANTITY_LO     = 8'h01;
   localparam logic [7:0]  BYTE_COUNT_TWO  = 8'h02;

   localparam logic [15:0] CRC_START     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic        is_write;
      logic [7:0]  slave_address;
      logic [15:0] register_address;
      logic [15:0] register_value;
   } mrf_desc_type;

   // one entry of the reflected crc-16 lookup table
   function automatic logic [15:0] crc_lut(input logic [7:0] idx);
      logic [15:0] c;
      c = {8'h00, idx};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/mrf_if.sv
interface mrf_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [7:0]  slave_address;
   logic [15:0] register_address;
   logic [15:0] register_value;

   modport source (output valid, output opcode, output slave_address,
                   output register_address, output register_value, input ready);
   modport sink   (input valid, input opcode, input slave_address,
                   input register_address, input register_value, output ready);
endinterface

interface mrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

### rtl/mrf_front.sv
module mrf_front (
   input  logic                 clock,
   input  logic                 reset,
   mrf_req_if.sink              req_ch,
   output logic                 push_valid,
   input  logic                 push_ready,
   output mrf_pkg::mrf_desc_type push_data
);
   import mrf_pkg::*;

   logic         valid_ff, valid_in;
   mrf_desc_type desc_ff, desc_in;
   logic         req_fire;

   assign req_ch.ready = !valid_ff || push_ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      desc_in  = desc_ff;
      if (req_fire) begin
         valid_in                 = 1'b1;
         desc_in.is_write         = (req_ch.opcode == OP_WRITE);
         desc_in.slave_address    = req_ch.slave_address;
         desc_in.register_address = req_ch.register_address;
         desc_in.register_value   = req_ch.register_value;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      desc_ff <= desc_in;
   end

   assign push_valid = valid_ff;
   assign push_data  = desc_ff;

endmodule

### rtl/mrf_queue.sv
module mrf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  mrf_pkg::mrf_desc_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output mrf_pkg::mrf_desc_type pop_data
);
   import mrf_pkg::*;

   mrf_desc_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                       push, pop;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QUEUE_PTR_W'(1);
   endfunction

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/mrf_back.sv
module mrf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  mrf_pkg::mrf_desc_type pop_data,
   mrf_rsp_if.source            rsp_ch
);
   import mrf_pkg::*;

   logic             active_ff, active_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]      crc_ff, crc_in;
   mrf_desc_type     desc_ff, desc_in;

   logic             rsp_fire, load;
   logic [IDX_W-1:0] crc_idx, last_idx;
   logic [7:0]       data_byte, out_byte;
   logic             is_last, in_crc;

   assign crc_idx  = desc_ff.is_write ? IDX_CRC_WR  : IDX_CRC_RD;
   assign last_idx = desc_ff.is_write ? IDX_LAST_WR : IDX_LAST_RD;
   assign is_last  = (idx_ff == last_idx);
   assign in_crc   = (idx_ff >= crc_idx);

   always_comb begin
      unique case (idx_ff)
         IDX_SLAVE:  data_byte = desc_ff.slave_address;
         IDX_FUNC:   data_byte = desc_ff.is_write ? FN_WRITE_MULTI : FN_READ_HOLDING;
         IDX_REG_HI: data_byte = desc_ff.register_address[15:8];
         IDX_REG_LO: data_byte = desc_ff.register_address[7:0];
         IDX_QTY_HI: data_byte = QUANTITY_HI;
         IDX_QTY_LO: data_byte = QUANTITY_LO;
         IDX_BCOUNT: data_byte = BYTE_COUNT_TWO;
         IDX_VAL_HI: data_byte = desc_ff.register_value[15:8];
         IDX_VAL_LO: data_byte = desc_ff.register_value[7:0];
         default:    data_byte = 8'h00;
      endcase
   end

   always_comb begin
      if (!in_crc) begin
         out_byte = data_byte;
      end else if (is_last) begin
         out_byte = crc_ff[15:8];
      end else begin
         out_byte = crc_ff[7:0];
      end
   end

   assign rsp_ch.valid      = active_ff;
   assign rsp_ch.frame_byte = out_byte;
   assign rsp_ch.last_byte  = is_last;

   assign rsp_fire  = rsp_ch.valid && rsp_ch.ready;
   assign pop_ready = !active_ff || (rsp_fire && is_last);
   assign load      = pop_valid && pop_ready;

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      desc_in   = desc_ff;
      if (load) begin
         active_in = 1'b1;
         idx_in    = '0;
         crc_in    = CRC_START;
         desc_in   = pop_data;
      end else if (rsp_fire) begin
         if (is_last) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
         // fold each data byte ahead of the crc field into the running crc as it leaves
         if (!in_crc) begin
            crc_in = {8'h00, crc_ff[15:8]} ^ crc_lut(crc_ff[7:0] ^ data_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      idx_ff  <= idx_in;
      crc_ff  <= crc_in;
      desc_ff <= desc_in;
   end

`ifndef SYNTHESIS
   a_idx_in_frame: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff <= last_idx))
      else $error("byte index ran past end of frame");

   a_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !is_last) |=> (active_ff && idx_ff == IDX_W'($past(idx_ff) + 4'd1)))
      else $error("frame did not advance by one byte");

   a_load: assert property (@(posedge clock) disable iff (reset)
      load |=> (active_ff && idx_ff == IDX_SLAVE && crc_ff == CRC_START))
      else $error("new frame did not start clean");

   a_no_pop_mid_frame: assert property (@(posedge clock) disable iff (reset)
      (active_ff && !(rsp_fire && is_last)) |-> !pop_ready)
      else $error("queue popped in the middle of a frame");
`endif

endmodule

### rtl/modbus_rtu_request_framer_core.sv
// a request passes the front register and the queue; the back end loads it, then offers its first byte
// frame bytes leave one per cycle while rsp_ch.ready is high; a read frame is 8 bytes, a write 11
// the back end's byte counter sets the rate; the next frame follows with no gap
// a two-entry queue between front and back lets requests land while a frame drains
// reset (synchronous, active high) empties the front register, the queue and the back end
module modbus_rtu_request_framer_core (
   input  logic      clock,
   input  logic      reset,
   mrf_req_if.sink   req_ch,
   mrf_rsp_if.source rsp_ch
);
   import mrf_pkg::*;

   logic         push_valid, push_ready;
   mrf_desc_type push_data;
   logic         pop_valid, pop_ready;
   mrf_desc_type pop_data;

   mrf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   mrf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mrf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

### sim/mrf_frame_checker.sv
`timescale 1ns / 1ps

module mrf_frame_checker (
   input  logic clock,
   input  logic reset,
   mrf_req_if   req_mon,
   mrf_rsp_if   rsp_mon,
   output int   fail_count,
   output int   bytes_pending,
   output int   bytes_checked
);
   import mrf_pkg::*;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } frame_beat_type;

   frame_beat_type expected_frame_bytes[$];
   int             mismatches;
   int             compared;

   // bitwise crc-16/modbus, one byte at a time
   function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                     input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void predict_frame(input logic        is_write,
                                         input logic [7:0]  slave_address,
                                         input logic [15:0] register_address,
                                         input logic [15:0] register_value);
      logic [7:0]  body [0:8];
      int          len;
      logic [15:0] crc;
      body[0] = slave_address;
      body[1] = (is_write == OP_WRITE) ? FN_WRITE_MULTI : FN_READ_HOLDING;
      body[2] = register_address[15:8];
      body[3] = register_address[7:0];
      body[4] = QUANTITY_HI;
      body[5] = QUANTITY_LO;
      len = 6;
      // the value only goes out on a write
      if (is_write == OP_WRITE) begin
         body[6] = BYTE_COUNT_TWO;
         body[7] = register_value[15:8];
         body[8] = register_value[7:0];
         len = 9;
      end
      crc = CRC_START;
      for (int k = 0; k < len; k++) begin
         crc = crc16_modbus_step(crc, body[k]);
         expected_frame_bytes.push_back('{body[k], 1'b0});
      end
      expected_frame_bytes.push_back('{crc[7:0], 1'b0});
      expected_frame_bytes.push_back('{crc[15:8], 1'b1});
   endfunction

   initial begin
      mismatches = 0;
      compared   = 0;
   end

   always @(posedge clock) begin
      frame_beat_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            predict_frame(req_mon.opcode, req_mon.slave_address,
                          req_mon.register_address, req_mon.register_value);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_frame_bytes.size() == 0) begin
               $error("frame_byte 0x%02h last_byte %0b with no request outstanding",
                      rsp_mon.frame_byte, rsp_mon.last_byte);
               mismatches++;
            end else begin
               want = expected_frame_bytes.pop_front();
               compared++;
               if (rsp_mon.frame_byte !== want.frame_byte) begin
                  $error("frame_byte: expected 0x%02h, actual 0x%02h",
                         want.frame_byte, rsp_mon.frame_byte);
                  mismatches++;
               end
               if (rsp_mon.last_byte !== want.last_byte) begin
                  $error("last_byte: expected %0b, actual %0b",
                         want.last_byte, rsp_mon.last_byte);
                  mismatches++;
               end
            end
         end
      end
      fail_count    <= mismatches;
      bytes_pending <= expected_frame_bytes.size();
      bytes_checked <= compared;
   end

endmodule

### sim/tb_modbus_rtu_request_framer_core.sv
`timescale 1ns / 1ps

module tb_modbus_rtu_request_framer_core;
   import mrf_pkg::*;

   localparam int RSP_HOLD_CYCLES = 80;
   localparam int STALL_LIMIT     = 2000;
   localparam int IDLE_PERCENT    = 29;

   typedef enum logic [1:0] {PH_RESET, PH_DIRECTED, PH_BURST, PH_RANDOM} stim_phase_type;

   logic           clock = 1'b0;
   logic           reset;
   stim_phase_type tb_phase;
   bit             gaps_on;
   int             reads_sent;
   int             writes_sent;
   int             idle_cycles;
   int             fail_count;
   int             bytes_pending;
   int             bytes_checked;

   mrf_req_if req_ch();
   mrf_rsp_if rsp_ch();

   modbus_rtu_request_framer_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   mrf_frame_checker frame_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .bytes_pending (bytes_pending),
      .bytes_checked (bytes_checked)
   );

   always #1 clock = ~clock;

   task automatic send_request(input logic        op,
                               input logic [7:0]  slave_address,
                               input logic [15:0] register_address,
                               input logic [15:0] register_value);
      while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.opcode           <= op;
      req_ch.slave_address    <= slave_address;
      req_ch.register_address <= register_address;
      req_ch.register_value   <= register_value;
      if (op == OP_WRITE) begin
         writes_sent++;
      end else begin
         reads_sent++;
      end
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random_request();
      send_request($urandom_range(1) ? OP_WRITE : OP_READ, 8'($urandom),
                   16'($urandom), 16'($urandom));
   endtask

   // pending count is registered, so look after the last beat has landed
   task automatic wait_frames_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
   endtask

   initial begin
      reset                   <= 1'b1;
      tb_phase                <= PH_RESET;
      req_ch.valid            <= 1'b0;
      req_ch.opcode           <= OP_READ;
      req_ch.slave_address    <= '0;
      req_ch.register_address <= '0;
      req_ch.register_value   <= '0;
      gaps_on     = 1'b1;
      reads_sent  = 0;
      writes_sent = 0;
      repeat (8) @(posedge clock);
      reset    <= 1'b0;
      tb_phase <= PH_DIRECTED;

      send_request(OP_READ,  8'h00, 16'h0000, 16'h0000);
      send_request(OP_READ,  8'hFF, 16'hFFFF, 16'hFFFF);
      send_request(OP_WRITE, 8'h00, 16'h0000, 16'h0000);
      send_request(OP_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_request(OP_WRITE, 8'h01, 16'h0001, 16'h0000);
      // same read with two values: the value must not reach the frame
      send_request(OP_READ,  8'hA5, 16'h1234, 16'hBEEF);
      send_request(OP_READ,  8'hA5, 16'h1234, 16'h0000);
      send_request(OP_WRITE, 8'h5A, 16'hAAAA, 16'h5555);
      send_request(OP_WRITE, 8'hA5, 16'h5555, 16'hAAAA);
      send_request(OP_READ,  8'h80, 16'h8000, 16'h0001);
      send_request(OP_WRITE, 8'h7F, 16'h7FFF, 16'h8000);
      send_request(OP_READ,  8'h01, 16'h00FF, 16'hFF00);
      send_request(OP_WRITE, 8'h11, 16'h0100, 16'h00FF);
      wait_frames_drained();

      // back to back while the output is held off, then no idling at all
      tb_phase <= PH_BURST;
      gaps_on = 1'b0;
      repeat (24) send_random_request();
      wait_frames_drained();

      tb_phase <= PH_RANDOM;
      gaps_on = 1'b1;
      repeat (64) send_random_request();
      wait_frames_drained();
      repeat (16) @(posedge clock);

      $display("covered %0d read and %0d write requests, %0d frame bytes compared",
               reads_sent, writes_sent, bytes_checked);
      $display("field extremes, value ignored on reads, burst under output hold-off, ",
               "random idling on both sides");
      if (fail_count == 0 && bytes_pending == 0) begin
         $display("PASS modbus_rtu_request_framer_core");
      end else begin
         $display("FAIL modbus_rtu_request_framer_core");
      end
      $finish;
   end

   initial begin
      bit held_off;
      held_off = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (tb_phase == PH_BURST && !held_off) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= (tb_phase == PH_BURST) || ($urandom_range(99) >= IDLE_PERCENT);
            @(posedge clock);
         end
      end
   end

   // watchdog: cycles with no beat on either channel
   initial idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL modbus_rtu_request_framer_core");
         $finish;
      end
   end

endmodule

### filelist.f
rtl/mrf_pkg.sv
rtl/mrf_if.sv
rtl/mrf_front.sv
rtl/mrf_queue.sv
rtl/mrf_back.sv
rtl/modbus_rtu_request_framer_core.sv
sim/mrf_frame_checker.sv
sim/tb_modbus_rtu_request_framer_core.sv
